// ===== hw/rtl/tlssni_pkg.sv =====
package tlssni_pkg;

    // One packet byte with the packet length that rides on the first byte.
    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic [15:0] packet_len;
    } in_item_t;

    // One result: a host name byte and/or the final status of a packet.
    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_valid;
        logic [2:0] status;
        logic       done_res;
    } out_item_t;

    // Parser phases.
    localparam logic [4:0] PH_CT            = 5'd0;
    localparam logic [4:0] PH_VER           = 5'd1;
    localparam logic [4:0] PH_RLEN          = 5'd2;
    localparam logic [4:0] PH_HTYPE         = 5'd3;
    localparam logic [4:0] PH_HLEN_CH       = 5'd4;
    localparam logic [4:0] PH_HLEN_OTHER    = 5'd5;
    localparam logic [4:0] PH_FIXED         = 5'd6;
    localparam logic [4:0] PH_SIDLEN        = 5'd7;
    localparam logic [4:0] PH_SID           = 5'd8;
    localparam logic [4:0] PH_CSLEN         = 5'd9;
    localparam logic [4:0] PH_CS            = 5'd10;
    localparam logic [4:0] PH_CMLEN         = 5'd11;
    localparam logic [4:0] PH_CM            = 5'd12;
    localparam logic [4:0] PH_EXTSLEN       = 5'd13;
    localparam logic [4:0] PH_EXTTYPE       = 5'd14;
    localparam logic [4:0] PH_EXTLEN_SNI    = 5'd15;
    localparam logic [4:0] PH_EXTLEN_OTHER  = 5'd16;
    localparam logic [4:0] PH_EXTBODY       = 5'd17;
    localparam logic [4:0] PH_LISTLEN       = 5'd18;
    localparam logic [4:0] PH_NAMETYPE      = 5'd19;
    localparam logic [4:0] PH_NAMELEN_HOST  = 5'd20;
    localparam logic [4:0] PH_NAMELEN_OTHER = 5'd21;
    localparam logic [4:0] PH_NAME          = 5'd22;
    localparam logic [4:0] PH_NAMESKIP      = 5'd23;
    localparam logic [4:0] PH_IGNORE        = 5'd24;

    // Status codes.
    localparam logic [2:0] ST_FOUND  = 3'd0;
    localparam logic [2:0] ST_NOT_HS = 3'd1;
    localparam logic [2:0] ST_NOT_CH = 3'd2;
    localparam logic [2:0] ST_LEN    = 3'd3;
    localparam logic [2:0] ST_NO_SNI = 3'd4;

    // Protocol constants.
    localparam logic [7:0]  CT_HANDSHAKE    = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [23:0] EXT_SERVER_NAME = 24'h000000;
    localparam int          FIXED_BYTES     = 34;

endpackage

// ===== hw/rtl/tls_client_hello_sni_extractor_core.sv =====
// A result is first held in the parser's result register and is then written into the queue,
// from which it can be popped.
// Throughput: one packet byte per cycle while full is low; the parser updates all counters for each accepted byte.
// Full rises only when the four-entry result queue holds two or more results.
// Reset (rst_n low, asynchronous) returns the parser to the record header and empties the queue.
module tls_client_hello_sni_extractor_core #(
    parameter int OFFSET_WIDTH = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  tlssni_pkg::in_item_t  in_data,
    output logic                  empty,
    input  logic                  pop,
    output tlssni_pkg::out_item_t out_data
);

    logic                  res_valid;
    tlssni_pkg::out_item_t res_item;
    logic                  accept;

    assign accept = push && !full;

    tlssni_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (in_data),
        .res_valid(res_valid),
        .res_item (res_item)
    );

    tlssni_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (res_valid),
        .wr_item    (res_item),
        .almost_full(full),
        .empty      (empty),
        .pop        (pop),
        .rd_item    (out_data)
    );

endmodule

// ===== hw/rtl/tlssni_front.sv =====
// Byte parser: walks the record and produces at most one result per byte.
module tlssni_front #(
    parameter int OFFSET_WIDTH = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tlssni_pkg::in_item_t in_item,
    output logic                 res_valid,
    output tlssni_pkg::out_item_t res_item
);

    localparam int OW = OFFSET_WIDTH;
    // Sums of a position and a 24-bit length need room for both.
    localparam int SW = (OW > 24 ? OW : 24) + 1;

    logic [4:0]    phase_reg, phase_next;
    logic [OW-1:0] pos_reg, pos_next;
    logic [16:0]   left_reg, left_next;
    logic [23:0]   acc_reg, acc_next;
    logic [15:0]   plen_reg, plen_next;
    logic [7:0]    ct_reg, ct_next;
    logic [OW-1:0] rec_end_reg, rec_end_next;
    logic [OW-1:0] hs_end_reg, hs_end_next;
    logic [OW-1:0] exts_end_reg, exts_end_next;
    logic [OW-1:0] ext_end_reg, ext_end_next;
    logic [OW-1:0] names_end_reg, names_end_next;
    logic          given_reg, given_next;

    // Per-byte working values.
    logic [4:0]    ph;
    logic [15:0]   len;
    logic          given;
    logic [SW-1:0] pos_w;
    logic [7:0]    b;
    logic [23:0]   acc_sh;
    logic [16:0]   left_dec;
    logic          field_done;
    logic [SW-1:0] e_sum;
    logic [SW-1:0] len_w;
    logic          ext_fits;
    logic          list_fits;
    logic          in_ext;
    logic          emit;
    tlssni_pkg::out_item_t r;

    always_comb
    begin
        b        = in_item.pkt_byte;
        ph       = phase_reg;
        len      = plen_reg;
        given    = given_reg;
        if (pos_reg == '0)
        begin
            len   = (in_item.packet_len == 16'd0) ? 16'd1 : in_item.packet_len;
            given = 1'b0;
            ph    = tlssni_pkg::PH_CT;
        end
        pos_w      = SW'(pos_reg) + SW'(1);
        len_w      = SW'(len);
        acc_sh     = {acc_reg[15:0], b};
        left_dec   = (left_reg != 17'd0) ? left_reg - 17'd1 : 17'd0;
        field_done = (left_dec == 17'd0);
        e_sum      = pos_w + SW'(acc_sh);
        ext_fits   = (pos_w + SW'(4)) <= SW'(exts_end_reg);
        list_fits  = (pos_w + SW'(3)) <= SW'(names_end_reg);
        in_ext     = pos_w < SW'(ext_end_reg);

        phase_next     = ph;
        pos_next       = pos_w[OW-1:0];
        left_next      = left_reg;
        acc_next       = acc_reg;
        plen_next      = len;
        ct_next        = ct_reg;
        rec_end_next   = rec_end_reg;
        hs_end_next    = hs_end_reg;
        exts_end_next  = exts_end_reg;
        ext_end_next   = ext_end_reg;
        names_end_next = names_end_reg;
        given_next     = given;
        emit           = 1'b0;
        r              = '0;

        case (ph)
            tlssni_pkg::PH_CT:
            begin
                ct_next    = b;
                phase_next = tlssni_pkg::PH_VER;
                left_next  = 17'd2;
                acc_next   = '0;
            end
            tlssni_pkg::PH_VER:
            begin
                left_next = left_dec;
                if (field_done)
                begin
                    phase_next = tlssni_pkg::PH_RLEN;
                    left_next  = 17'd2;
                    acc_next   = '0;
                end
            end
            tlssni_pkg::PH_RLEN:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (ct_reg != tlssni_pkg::CT_HANDSHAKE)
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_NOT_HS;
                    end
                    else if (e_sum > len_w)
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else
                    begin
                        rec_end_next = e_sum[OW-1:0];
                        phase_next   = tlssni_pkg::PH_HTYPE;
                    end
                end
            end
            tlssni_pkg::PH_HTYPE:
            begin
                phase_next = (b == tlssni_pkg::HS_CLIENT_HELLO) ?
                             tlssni_pkg::PH_HLEN_CH : tlssni_pkg::PH_HLEN_OTHER;
                left_next  = 17'd3;
                acc_next   = '0;
            end
            tlssni_pkg::PH_HLEN_CH, tlssni_pkg::PH_HLEN_OTHER:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (ph == tlssni_pkg::PH_HLEN_OTHER)
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_NOT_CH;
                    end
                    else if (e_sum > SW'(rec_end_reg))
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else
                    begin
                        hs_end_next = e_sum[OW-1:0];
                        phase_next  = tlssni_pkg::PH_FIXED;
                        left_next   = 17'(tlssni_pkg::FIXED_BYTES);
                        acc_next    = '0;
                    end
                end
            end
            tlssni_pkg::PH_FIXED:
            begin
                left_next = left_dec;
                if (field_done)
                begin
                    phase_next = tlssni_pkg::PH_SIDLEN;
                end
            end
            tlssni_pkg::PH_SIDLEN, tlssni_pkg::PH_CMLEN:
            begin
                acc_next = '0;
                if (b == 8'd0)
                begin
                    phase_next = (ph == tlssni_pkg::PH_SIDLEN) ?
                                 tlssni_pkg::PH_CSLEN : tlssni_pkg::PH_EXTSLEN;
                    left_next  = 17'd2;
                end
                else
                begin
                    phase_next = (ph == tlssni_pkg::PH_SIDLEN) ?
                                 tlssni_pkg::PH_SID : tlssni_pkg::PH_CM;
                    left_next  = 17'(b);
                end
            end
            tlssni_pkg::PH_SID, tlssni_pkg::PH_CM:
            begin
                left_next = left_dec;
                if (field_done)
                begin
                    phase_next = (ph == tlssni_pkg::PH_SID) ?
                                 tlssni_pkg::PH_CSLEN : tlssni_pkg::PH_EXTSLEN;
                    left_next  = 17'd2;
                    acc_next   = '0;
                end
            end
            tlssni_pkg::PH_CSLEN:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (acc_sh == 24'd0)
                    begin
                        phase_next = tlssni_pkg::PH_CMLEN;
                    end
                    else
                    begin
                        phase_next = tlssni_pkg::PH_CS;
                        left_next  = acc_sh[16:0];
                        acc_next   = '0;
                    end
                end
            end
            tlssni_pkg::PH_CS:
            begin
                left_next = left_dec;
                if (field_done)
                begin
                    phase_next = tlssni_pkg::PH_CMLEN;
                end
            end
            tlssni_pkg::PH_EXTSLEN:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (e_sum > SW'(hs_end_reg) || e_sum > len_w)
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else
                    begin
                        exts_end_next = e_sum[OW-1:0];
                        // Fit test uses the new block end.
                        if ((pos_w + SW'(4)) <= SW'(e_sum[OW-1:0]))
                        begin
                            phase_next = tlssni_pkg::PH_EXTTYPE;
                            left_next  = 17'd2;
                            acc_next   = '0;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            r.status = tlssni_pkg::ST_NO_SNI;
                        end
                    end
                end
            end
            tlssni_pkg::PH_EXTTYPE:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    phase_next = (acc_sh == tlssni_pkg::EXT_SERVER_NAME) ?
                                 tlssni_pkg::PH_EXTLEN_SNI : tlssni_pkg::PH_EXTLEN_OTHER;
                    left_next  = 17'd2;
                    acc_next   = '0;
                end
            end
            tlssni_pkg::PH_EXTLEN_SNI, tlssni_pkg::PH_EXTLEN_OTHER:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (e_sum > SW'(exts_end_reg))
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else
                    begin
                        ext_end_next = e_sum[OW-1:0];
                        if (ph == tlssni_pkg::PH_EXTLEN_SNI)
                        begin
                            if (acc_sh < 24'd2)
                            begin
                                emit     = 1'b1;
                                r.status = tlssni_pkg::ST_LEN;
                            end
                            else
                            begin
                                phase_next = tlssni_pkg::PH_LISTLEN;
                                left_next  = 17'd2;
                                acc_next   = '0;
                            end
                        end
                        else if (acc_sh == 24'd0)
                        begin
                            if (ext_fits)
                            begin
                                phase_next = tlssni_pkg::PH_EXTTYPE;
                                left_next  = 17'd2;
                                acc_next   = '0;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                r.status = tlssni_pkg::ST_NO_SNI;
                            end
                        end
                        else
                        begin
                            phase_next = tlssni_pkg::PH_EXTBODY;
                        end
                    end
                end
            end
            tlssni_pkg::PH_EXTBODY:
            begin
                if (!in_ext)
                begin
                    if (ext_fits)
                    begin
                        phase_next = tlssni_pkg::PH_EXTTYPE;
                        left_next  = 17'd2;
                        acc_next   = '0;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_NO_SNI;
                    end
                end
            end
            tlssni_pkg::PH_LISTLEN:
            begin
                left_next = left_dec;
                acc_next  = acc_sh;
                if (field_done)
                begin
                    if (e_sum > SW'(ext_end_reg))
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else
                    begin
                        names_end_next = e_sum[OW-1:0];
                        if ((pos_w + SW'(3)) <= SW'(e_sum[OW-1:0]))
                        begin
                            phase_next = tlssni_pkg::PH_NAMETYPE;
                        end
                        else if (!in_ext)
                        begin
                            if (ext_fits)
                            begin
                                phase_next = tlssni_pkg::PH_EXTTYPE;
                                left_next  = 17'd2;
                                acc_next   = '0;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                r.status = tlssni_pkg::ST_NO_SNI;
                            end
                        end
                        else
                        begin
                            phase_next = tlssni_pkg::PH_EXTBODY;
                        end
                    end
                end
            end
            tlssni_pkg::PH_NAMETYPE:
            begin
                phase_next = (b == 8'd0) ?
                             tlssni_pkg::PH_NAMELEN_HOST : tlssni_pkg::PH_NAMELEN_OTHER;
                left_next  = 17'd2;
                acc_next   = '0;
            end
            tlssni_pkg::PH_NAMELEN_HOST, tlssni_pkg::PH_NAMELEN_OTHER,
            tlssni_pkg::PH_NAMESKIP:
            begin
                left_next = left_dec;
                if (ph != tlssni_pkg::PH_NAMESKIP)
                begin
                    acc_next = acc_sh;
                end
                if (field_done)
                begin
                    if (ph != tlssni_pkg::PH_NAMESKIP && e_sum > SW'(names_end_reg))
                    begin
                        emit     = 1'b1;
                        r.status = tlssni_pkg::ST_LEN;
                    end
                    else if (ph == tlssni_pkg::PH_NAMELEN_HOST)
                    begin
                        if (acc_sh == 24'd0)
                        begin
                            emit     = 1'b1;
                            r.status = tlssni_pkg::ST_FOUND;
                        end
                        else
                        begin
                            phase_next = tlssni_pkg::PH_NAME;
                            left_next  = acc_sh[16:0];
                            acc_next   = '0;
                        end
                    end
                    else if (ph == tlssni_pkg::PH_NAMELEN_OTHER && acc_sh != 24'd0)
                    begin
                        phase_next = tlssni_pkg::PH_NAMESKIP;
                        left_next  = acc_sh[16:0];
                        acc_next   = '0;
                    end
                    // Back to the name list loop.
                    else if (list_fits)
                    begin
                        phase_next = tlssni_pkg::PH_NAMETYPE;
                    end
                    else if (!in_ext)
                    begin
                        if (ext_fits)
                        begin
                            phase_next = tlssni_pkg::PH_EXTTYPE;
                            left_next  = 17'd2;
                            acc_next   = '0;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            r.status = tlssni_pkg::ST_NO_SNI;
                        end
                    end
                    else
                    begin
                        phase_next = tlssni_pkg::PH_EXTBODY;
                    end
                end
            end
            tlssni_pkg::PH_NAME:
            begin
                left_next    = left_dec;
                emit         = 1'b1;
                r.name_byte  = b;
                r.name_valid = 1'b1;
                r.status     = tlssni_pkg::ST_FOUND;
                if (field_done)
                begin
                    r.done_res = 1'b1;
                    given_next = 1'b1;
                    phase_next = tlssni_pkg::PH_IGNORE;
                end
            end
            default:
            begin
            end
        endcase

        // A decided status ends parsing of this packet.
        if (emit && !r.name_valid)
        begin
            r.done_res = 1'b1;
            given_next = 1'b1;
            phase_next = tlssni_pkg::PH_IGNORE;
        end

        // Final byte of the packet.
        if (pos_w >= len_w)
        begin
            if (!emit && !given)
            begin
                emit     = 1'b1;
                r        = '0;
                r.status = tlssni_pkg::ST_LEN;
                r.done_res = 1'b1;
            end
            pos_next   = '0;
            phase_next = tlssni_pkg::PH_CT;
            given_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tlssni_pkg::PH_CT;
            pos_reg       <= '0;
            left_reg      <= '0;
            acc_reg       <= '0;
            plen_reg      <= '0;
            ct_reg        <= '0;
            rec_end_reg   <= '0;
            hs_end_reg    <= '0;
            exts_end_reg  <= '0;
            ext_end_reg   <= '0;
            names_end_reg <= '0;
            given_reg     <= 1'b0;
            res_valid     <= 1'b0;
            res_item      <= '0;
        end
        else
        begin
            res_valid <= in_valid && emit;
            if (in_valid)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                left_reg      <= left_next;
                acc_reg       <= acc_next;
                plen_reg      <= plen_next;
                ct_reg        <= ct_next;
                rec_end_reg   <= rec_end_next;
                hs_end_reg    <= hs_end_next;
                exts_end_reg  <= exts_end_next;
                ext_end_reg   <= ext_end_next;
                names_end_reg <= names_end_next;
                given_reg     <= given_next;
                res_item      <= r;
            end
        end
    end

endmodule

// ===== hw/rtl/tlssni_queue.sv =====
// Small result queue between the parser and the consumer.
module tlssni_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  tlssni_pkg::out_item_t wr_item,
    output logic                  almost_full,
    output logic                  empty,
    input  logic                  pop,
    output tlssni_pkg::out_item_t rd_item
);

    localparam int DEPTH = 4;

    tlssni_pkg::out_item_t mem_reg [DEPTH];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       rd_en;

    assign empty = (cnt_reg == 3'd0);
    // Two slots kept free: one for the item in the parser register, one in flight.
    assign almost_full = (cnt_reg >= 3'd2);
    assign rd_en   = pop && !empty;
    assign rd_item = mem_reg[rptr_reg];
    assign cnt_next = cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule
